// ===== design/pges_pkg.sv =====
`timescale 1ns / 1ps

package pges_pkg;

    // fixed word widths
    localparam int WORD_W        = 32;
    localparam int RAD_W         = 8;
    localparam int MASS_W        = 16;
    localparam int GRAV_W        = 16;
    localparam int TS_W          = 16;
    localparam int TS_FRAC       = 16;
    localparam int MARGIN_W      = 8;
    localparam int MAG_W         = WORD_W + 1;
    localparam int D2_W          = 2 * MAG_W;
    localparam int DIST_W        = MAG_W;
    localparam int FORCE_W       = WORD_W - 1;
    localparam int PROD_W        = FORCE_W + MAG_W;
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY   = 2'd0,
        CFG_TIME_STEP = 2'd1,
        CFG_MARGIN    = 2'd2
    } t_cfg_idx;

    localparam logic [GRAV_W-1:0]   GRAVITY_RST   = 16'd400;
    localparam logic [TS_W-1:0]     TIME_STEP_RST = 16'd410;
    localparam logic [MARGIN_W-1:0] MARGIN_RST    = 8'd10;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic [RAD_W-1:0]         body_radius;
        logic signed [WORD_W-1:0] other_center_x;
        logic signed [WORD_W-1:0] other_center_y;
        logic [MASS_W-1:0]        other_mass;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_pos_x;
        logic signed [WORD_W-1:0] new_pos_y;
        logic signed [WORD_W-1:0] new_vel_x;
        logic signed [WORD_W-1:0] new_vel_y;
        logic signed [WORD_W-1:0] center_x;
        logic signed [WORD_W-1:0] center_y;
        logic                     contact;
    } t_out_beat;

    // state that rides along the pipeline with each beat
    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] center_x;
        logic signed [WORD_W-1:0] center_y;
        logic                     neg_x;
        logic                     neg_y;
        logic [MAG_W-1:0]         mag_x;
        logic [MAG_W-1:0]         mag_y;
        logic                     contact;
        logic [WORD_W-1:0]        gm;
        logic [DIST_W-1:0]        sep;
        logic [FORCE_W-1:0]       force_mag;
    } t_side;

    // clamp a two-bit-extended sum to the signed word range
    function automatic logic [WORD_W-1:0] sat_word(input logic [WORD_W+1:0] v);
        logic [WORD_W-1:0] res;
        if (v[WORD_W+1:WORD_W-1] == 3'b000 || v[WORD_W+1:WORD_W-1] == 3'b111) begin
            res = v[WORD_W-1:0];
        end else if (v[WORD_W+1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== design/pges_if.sv =====
`timescale 1ns / 1ps

interface pges_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/pairwise_gravity_euler_step.sv =====
`timescale 1ns / 1ps

// Pairwise gravity step with an explicit Euler update, signed fixed point.
// i_in carries one beat per body pair (body position, velocity, radius and
// the other body's centre and mass); o_out carries one result beat per input
// beat, in order: new position, new velocity, the centre used, contact flag.
// Constants are written through i_cfg_we / i_cfg_idx / i_cfg_data: index 0
// gravity constant, 1 time step (Q0.16), 2 contact margin; other indexes are
// ignored. Write them only while no beat is in flight.
// One beat enters per cycle unless the pipeline holds, as described below. The
// depth comes from the square root (one root bit per stage, 33 stages) and
// the two restoring dividers (32 stages each: force over distance squared,
// then acceleration per axis over distance).
// Reset clears every stage's valid bit and loads the default constants
// (400, 410, 10). When o_out.ready is low while a result is held, the whole
// pipeline holds and i_in.ready drops; nothing is lost or repeated.
module pairwise_gravity_euler_step #(
    parameter int FRAC_BITS = pges_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pges_if.sink                              i_in,
    pges_if.source                            o_out,
    input  logic                              i_cfg_we,
    input  logic [pges_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pges_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pges_pkg::*;

    localparam int FNUM_W = WORD_W + 3 * FRAC_BITS;

    logic [GRAV_W-1:0]   r_gravity;
    logic [TS_W-1:0]     r_time_step;
    logic [MARGIN_W-1:0] r_margin;

    logic              w_en;
    logic              w_fr_valid;
    logic [D2_W-1:0]   w_fr_d2;
    t_side             w_fr_side;
    logic              w_sq_valid;
    logic [DIST_W-1:0] w_sq_root;
    t_side             w_sq_side;

    logic              r_m1_valid;
    t_side             r_m1_side;
    logic [D2_W-1:0]   r_m1_den;
    t_side             n_m1_side;
    logic [D2_W-1:0]   n_m1_den;

    logic [FNUM_W-1:0]  w_fnum  [1];
    logic [FORCE_W-1:0] w_force [1];
    logic               w_fd_valid;
    t_side              w_fd_side;

    logic               r_m2_valid;
    t_side              r_m2_side;
    logic [PROD_W-1:0]  r_m2_prod [2];
    t_side              n_m2_side;
    logic [PROD_W-1:0]  n_m2_prod [2];

    logic [FORCE_W-1:0] w_acc [2];
    logic               w_ad_valid;
    t_side              w_ad_side;

    logic               w_out_valid;
    t_out_beat          w_out_beat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GRAVITY_RST;
            r_time_step <= TIME_STEP_RST;
            r_margin    <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRAVITY:   r_gravity   <= i_cfg_data[GRAV_W-1:0];
                CFG_TIME_STEP: r_time_step <= i_cfg_data[TS_W-1:0];
                CFG_MARGIN:    r_margin    <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a held result is not taken
    assign w_en        = !w_out_valid || o_out.ready;
    assign i_in.ready  = w_en;

    pges_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in.valid),
        .i_beat    (i_in.payload),
        .i_gravity (r_gravity),
        .i_margin  (r_margin),
        .o_valid   (w_fr_valid),
        .o_d2      (w_fr_d2),
        .o_side    (w_fr_side)
    );

    pges_isqrt #(
        .ROOT_W (DIST_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_rad   (w_fr_d2),
        .i_side  (w_fr_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // distance squared for the force divider
    always_comb begin
        n_m1_side     = w_sq_side;
        n_m1_side.sep = w_sq_root;
        n_m1_den      = w_sq_root * w_sq_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_side <= n_m1_side;
            r_m1_den  <= n_m1_den;
        end
    end

    assign w_fnum[0] = {r_m1_side.gm, {(3 * FRAC_BITS){1'b0}}};

    pges_div #(
        .NUM_W (FNUM_W),
        .DEN_W (D2_W),
        .Q_W   (FORCE_W),
        .LANES (1)
    ) u_force_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m1_valid),
        .i_num   (w_fnum),
        .i_den   (r_m1_den),
        .i_side  (r_m1_side),
        .o_valid (w_fd_valid),
        .o_quo   (w_force),
        .o_side  (w_fd_side)
    );

    // force along each axis before the division by distance
    always_comb begin
        n_m2_side           = w_fd_side;
        n_m2_side.force_mag = w_force[0];
        n_m2_prod[0]        = w_force[0] * w_fd_side.mag_x;
        n_m2_prod[1]        = w_force[0] * w_fd_side.mag_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m2_valid <= w_fd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_side    <= n_m2_side;
            r_m2_prod[0] <= n_m2_prod[0];
            r_m2_prod[1] <= n_m2_prod[1];
        end
    end

    pges_div #(
        .NUM_W (PROD_W),
        .DEN_W (DIST_W),
        .Q_W   (FORCE_W),
        .LANES (2)
    ) u_acc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m2_valid),
        .i_num   (r_m2_prod),
        .i_den   (r_m2_side.sep),
        .i_side  (r_m2_side),
        .o_valid (w_ad_valid),
        .o_quo   (w_acc),
        .o_side  (w_ad_side)
    );

    pges_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_ad_valid),
        .i_acc_x     (w_acc[0]),
        .i_acc_y     (w_acc[1]),
        .i_side      (w_ad_side),
        .i_time_step (r_time_step),
        .o_valid     (w_out_valid),
        .o_beat      (w_out_beat)
    );

    assign o_out.valid   = w_out_valid;
    assign o_out.payload = w_out_beat;

endmodule

// ===== design/pges_front.sv =====
`timescale 1ns / 1ps

module pges_front #(
    parameter int FRAC_BITS = pges_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  pges_pkg::t_in_beat              i_beat,
    input  logic [pges_pkg::GRAV_W-1:0]     i_gravity,
    input  logic [pges_pkg::MARGIN_W-1:0]   i_margin,
    output logic                            o_valid,
    output logic [pges_pkg::D2_W-1:0]       o_d2,
    output pges_pkg::t_side                 o_side
);
    import pges_pkg::*;

    localparam int LIM_W = MARGIN_W + 1 + FRAC_BITS;
    localparam int SQ_W  = 2 * LIM_W;

    logic                     r1_valid;
    t_in_beat                 r1_beat;
    logic                     r2_valid;
    t_side                    r2_side;
    logic signed [WORD_W-1:0] r2_ox;
    logic signed [WORD_W-1:0] r2_oy;
    logic [RAD_W-1:0]         r2_rad;
    logic [MASS_W-1:0]        r2_mass;
    logic                     r3_valid;
    t_side                    r3_side;
    logic [LIM_W-1:0]         r3_lim;
    logic [MASS_W-1:0]        r3_mass;
    logic                     r4_valid;
    t_side                    r4_side;
    logic [D2_W-1:0]          r4_sxx;
    logic [D2_W-1:0]          r4_syy;
    logic [SQ_W-1:0]          r4_limsq;
    logic                     r5_valid;
    t_side                    r5_side;
    logic [D2_W-1:0]          r5_d2;

    logic [WORD_W-1:0] n_radq;
    t_side             n2_side;
    logic [MAG_W-1:0]  n_dx;
    logic [MAG_W-1:0]  n_dy;
    t_side             n3_side;
    logic [LIM_W-1:0]  n_lim;
    t_side             n4_side;
    logic [D2_W-1:0]   n_sxx;
    logic [D2_W-1:0]   n_syy;
    logic [SQ_W-1:0]   n_limsq;
    logic [D2_W-1:0]   n_d2;
    t_side             n5_side;

    // body centre: position plus radius on both axes
    always_comb begin
        n_radq           = WORD_W'({r1_beat.body_radius, {FRAC_BITS{1'b0}}});
        n2_side          = '0;
        n2_side.pos_x    = r1_beat.pos_x;
        n2_side.pos_y    = r1_beat.pos_y;
        n2_side.vel_x    = r1_beat.vel_x;
        n2_side.vel_y    = r1_beat.vel_y;
        n2_side.center_x = sat_word({{2{r1_beat.pos_x[WORD_W-1]}}, r1_beat.pos_x}
                                    + {2'b00, n_radq});
        n2_side.center_y = sat_word({{2{r1_beat.pos_y[WORD_W-1]}}, r1_beat.pos_y}
                                    + {2'b00, n_radq});
    end

    // offset to the other centre as sign and magnitude, contact limit
    always_comb begin
        n_dx          = {r2_ox[WORD_W-1], r2_ox}
                        - {r2_side.center_x[WORD_W-1], r2_side.center_x};
        n_dy          = {r2_oy[WORD_W-1], r2_oy}
                        - {r2_side.center_y[WORD_W-1], r2_side.center_y};
        n3_side       = r2_side;
        n3_side.neg_x = n_dx[MAG_W-1];
        n3_side.neg_y = n_dy[MAG_W-1];
        n3_side.mag_x = n_dx[MAG_W-1] ? (~n_dx + MAG_W'(1)) : n_dx;
        n3_side.mag_y = n_dy[MAG_W-1] ? (~n_dy + MAG_W'(1)) : n_dy;
        n_lim         = {({1'b0, r2_rad} + {1'b0, i_margin}), {FRAC_BITS{1'b0}}};
    end

    // squares and the mass product
    always_comb begin
        n_sxx      = r3_side.mag_x * r3_side.mag_x;
        n_syy      = r3_side.mag_y * r3_side.mag_y;
        n_limsq    = r3_lim * r3_lim;
        n4_side    = r3_side;
        n4_side.gm = i_gravity * r3_mass;
    end

    // squared distance and contact test
    always_comb begin
        n_d2            = r4_sxx + r4_syy;
        n5_side         = r4_side;
        n5_side.contact = n_d2 <= D2_W'(r4_limsq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_beat  <= i_beat;
            r2_side  <= n2_side;
            r2_ox    <= r1_beat.other_center_x;
            r2_oy    <= r1_beat.other_center_y;
            r2_rad   <= r1_beat.body_radius;
            r2_mass  <= r1_beat.other_mass;
            r3_side  <= n3_side;
            r3_lim   <= n_lim;
            r3_mass  <= r2_mass;
            r4_side  <= n4_side;
            r4_sxx   <= n_sxx;
            r4_syy   <= n_syy;
            r4_limsq <= n_limsq;
            r5_side  <= n5_side;
            r5_d2    <= n_d2;
        end
    end

    assign o_valid = r5_valid;
    assign o_d2    = r5_d2;
    assign o_side  = r5_side;

endmodule

// ===== design/pges_isqrt.sv =====
`timescale 1ns / 1ps

module pges_isqrt #(
    parameter int ROOT_W = pges_pkg::DIST_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  pges_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output pges_pkg::t_side       o_side
);
    import pges_pkg::*;

    localparam int RADICAND_W = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CUR_W      = REM_W + 2;

    logic                  r_valid [ROOT_W];
    logic [RADICAND_W-1:0] r_rad   [ROOT_W];
    logic [REM_W-1:0]      r_rem   [ROOT_W];
    logic [ROOT_W-1:0]     r_root  [ROOT_W];
    t_side                 r_side  [ROOT_W];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic                  a_valid;
        logic [RADICAND_W-1:0] a_rad;
        logic [REM_W-1:0]      a_rem;
        logic [ROOT_W-1:0]     a_root;
        t_side                 a_side;
        logic [CUR_W-1:0]      n_cur;
        logic [CUR_W-1:0]      n_trial;
        logic                  n_ge;

        if (k == 0) begin : g_first
            assign a_valid = i_valid;
            assign a_rad   = i_rad;
            assign a_rem   = '0;
            assign a_root  = '0;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_valid = r_valid[k-1];
            assign a_rad   = r_rad[k-1];
            assign a_rem   = r_rem[k-1];
            assign a_root  = r_root[k-1];
            assign a_side  = r_side[k-1];
        end

        assign n_cur   = {a_rem, a_rad[RADICAND_W-1 -: 2]};
        assign n_trial = CUR_W'({a_root, 2'b01});
        assign n_ge    = n_cur >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? REM_W'(n_cur - n_trial) : REM_W'(n_cur);
                r_root[k] <= {a_root[ROOT_W-2:0], n_ge};
                r_rad[k]  <= {a_rad[RADICAND_W-3:0], 2'b00};
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ===== design/pges_div.sv =====
`timescale 1ns / 1ps

module pges_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int Q_W   = 31,
    parameter int LANES = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num [LANES],
    input  logic [DEN_W-1:0]   i_den,
    input  pges_pkg::t_side    i_side,
    output logic               o_valid,
    output logic [Q_W-1:0]     o_quo [LANES],
    output pges_pkg::t_side    o_side
);
    import pges_pkg::*;

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic             r_valid [Q_W+1];
    logic [DEN_W-1:0] r_den   [Q_W+1];
    t_side            r_side  [Q_W+1];
    logic [DEN_W-1:0] r_rem   [Q_W+1][LANES];
    logic [Q_W-1:0]   r_low   [Q_W+1][LANES];
    logic [Q_W-1:0]   r_q     [Q_W+1][LANES];
    logic             r_ovf   [Q_W+1][LANES];

    // entry: a quotient beyond the result range saturates, else the top
    // part of the numerator is the starting remainder
    for (genvar l = 0; l < LANES; l++) begin : g_entry
        logic [HI_W-1:0] n_hi;
        logic            n_ovf;

        assign n_hi  = i_num[l][NUM_W-1:Q_W];
        assign n_ovf = CMP_W'(n_hi) >= CMP_W'(i_den);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= DEN_W'(n_hi);
                r_low[0][l] <= i_num[l][Q_W-1:0];
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] n_cur;
            logic           n_ge;

            assign n_cur = {r_rem[k-1][l], r_low[k-1][l][Q_W-1]};
            assign n_ge  = n_cur >= {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= n_ge ? DEN_W'(n_cur - {1'b0, r_den[k-1]})
                                        : DEN_W'(n_cur);
                    r_low[k][l] <= {r_low[k-1][l][Q_W-2:0], 1'b0};
                    r_q[k][l]   <= {r_q[k-1][l][Q_W-2:0], n_ge};
                    r_ovf[k][l] <= r_ovf[k-1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_ovf[Q_W][l] ? {Q_W{1'b1}} : r_q[Q_W][l];
    end

    assign o_valid = r_valid[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// ===== design/pges_update.sv =====
`timescale 1ns / 1ps

module pges_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [pges_pkg::FORCE_W-1:0]  i_acc_x,
    input  logic [pges_pkg::FORCE_W-1:0]  i_acc_y,
    input  pges_pkg::t_side               i_side,
    input  logic [pges_pkg::TS_W-1:0]     i_time_step,
    output logic                          o_valid,
    output pges_pkg::t_out_beat           o_beat
);
    import pges_pkg::*;

    localparam int DVP_W = FORCE_W + TS_W;

    logic               r1_valid;
    t_side              r1_side;
    logic [FORCE_W-1:0] r1_dv_x;
    logic [FORCE_W-1:0] r1_dv_y;
    logic               r2_valid;
    t_side              r2_side;
    logic [WORD_W-1:0]  r2_nv_x;
    logic [WORD_W-1:0]  r2_nv_y;
    logic               r3_valid;
    t_out_beat          r3_beat;

    logic [DVP_W-1:0]  n_prod_x;
    logic [DVP_W-1:0]  n_prod_y;
    logic [WORD_W-1:0] n_dv_x;
    logic [WORD_W-1:0] n_dv_y;
    logic [WORD_W-1:0] n_nv_x;
    logic [WORD_W-1:0] n_nv_y;
    t_out_beat         n3_beat;

    // velocity change magnitude: acceleration times the step
    always_comb begin
        n_prod_x = i_acc_x * i_time_step;
        n_prod_y = i_acc_y * i_time_step;
    end

    // signed velocity update, zeroed on contact
    always_comb begin
        n_dv_x = r1_side.neg_x ? (~{1'b0, r1_dv_x} + WORD_W'(1)) : {1'b0, r1_dv_x};
        n_dv_y = r1_side.neg_y ? (~{1'b0, r1_dv_y} + WORD_W'(1)) : {1'b0, r1_dv_y};
        n_nv_x = sat_word({{2{r1_side.vel_x[WORD_W-1]}}, r1_side.vel_x}
                          + {{2{n_dv_x[WORD_W-1]}}, n_dv_x});
        n_nv_y = sat_word({{2{r1_side.vel_y[WORD_W-1]}}, r1_side.vel_y}
                          + {{2{n_dv_y[WORD_W-1]}}, n_dv_y});
        if (r1_side.contact) begin
            n_nv_x = '0;
            n_nv_y = '0;
        end
    end

    // position update; a zero velocity keeps the position on contact
    always_comb begin
        n3_beat.new_pos_x = sat_word({{2{r2_side.pos_x[WORD_W-1]}}, r2_side.pos_x}
                                     + {{2{r2_nv_x[WORD_W-1]}}, r2_nv_x});
        n3_beat.new_pos_y = sat_word({{2{r2_side.pos_y[WORD_W-1]}}, r2_side.pos_y}
                                     + {{2{r2_nv_y[WORD_W-1]}}, r2_nv_y});
        n3_beat.new_vel_x = r2_nv_x;
        n3_beat.new_vel_y = r2_nv_y;
        n3_beat.center_x  = r2_side.center_x;
        n3_beat.center_y  = r2_side.center_y;
        n3_beat.contact   = r2_side.contact;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= i_side;
            r1_dv_x <= n_prod_x[DVP_W-1:TS_FRAC];
            r1_dv_y <= n_prod_y[DVP_W-1:TS_FRAC];
            r2_side <= r1_side;
            r2_nv_x <= n_nv_x;
            r2_nv_y <= n_nv_y;
            r3_beat <= n3_beat;
        end
    end

    assign o_valid = r3_valid;
    assign o_beat  = r3_beat;

endmodule

// ===== tb/pairwise_gravity_euler_step_tb.sv =====
`timescale 1ns / 1ps

module pairwise_gravity_euler_step_tb;
    import pges_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int PIPE_LAT = 107;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pges_if #(.t_payload(t_in_beat))  in_if ();
    pges_if #(.t_payload(t_out_beat)) out_if ();

    pairwise_gravity_euler_step u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // our copy of the constants
    logic [GRAV_W-1:0]   grav_k;
    logic [TS_W-1:0]     step_k;
    logic [MARGIN_W-1:0] margin_k;

    t_in_beat  pending_pairs[$];
    t_out_beat expected_steps[$];
    int        fail_cnt = 0;
    bit        steady_send = 1'b0;
    bit        steady_take = 1'b0;

    always #10 i_clk = ~i_clk;

    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // velocity change along one axis
    function automatic longint axis_kick(input logic [127:0] frc, input longint d,
                                         input logic [127:0] sep);
        logic [127:0] mag;
        logic [127:0] acc;
        logic [127:0] dv;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        acc = (frc * mag) / sep;
        dv  = (acc * 128'(step_k)) >> 16;
        return (d < 0) ? -longint'(dv[63:0]) : longint'(dv[63:0]);
    endfunction

    // euler step of one body toward the other
    function automatic t_out_beat gravity_step(input t_in_beat b);
        t_out_beat r;
        longint px, py, vx, vy, cx, cy, dx, dy, nvx, nvy, npx, npy;
        logic [127:0] ux, uy, d2, lim, cand, sep, q1, frc;
        px = longint'(b.pos_x);
        py = longint'(b.pos_y);
        vx = longint'(b.vel_x);
        vy = longint'(b.vel_y);
        cx = clamp_word(px + (longint'(b.body_radius) << FRAC));
        cy = clamp_word(py + (longint'(b.body_radius) << FRAC));
        dx = longint'(b.other_center_x) - cx;
        dy = longint'(b.other_center_y) - cy;
        ux = (dx < 0) ? 128'(-dx) : 128'(dx);
        uy = (dy < 0) ? 128'(-dy) : 128'(dy);
        d2 = ux * ux + uy * uy;
        lim = (128'(b.body_radius) + 128'(margin_k)) << FRAC;
        r.center_x = cx[31:0];
        r.center_y = cy[31:0];
        if (d2 <= lim * lim) begin
            r.contact   = 1'b1;
            r.new_vel_x = '0;
            r.new_vel_y = '0;
            r.new_pos_x = b.pos_x;
            r.new_pos_y = b.pos_y;
        end else begin
            sep = '0;
            for (int k = 33; k >= 0; k--) begin
                cand = sep | (128'd1 << k);
                if (cand * cand <= d2) sep = cand;
            end
            q1  = ((128'(grav_k) * 128'(b.other_mass)) << (3 * FRAC)) / sep;
            frc = q1 / sep;
            if (frc > 128'd2147483647) frc = 128'd2147483647;
            nvx = clamp_word(vx + axis_kick(frc, dx, sep));
            nvy = clamp_word(vy + axis_kick(frc, dy, sep));
            npx = clamp_word(px + nvx);
            npy = clamp_word(py + nvy);
            r.contact   = 1'b0;
            r.new_vel_x = nvx[31:0];
            r.new_vel_y = nvy[31:0];
            r.new_pos_x = npx[31:0];
            r.new_pos_y = npy[31:0];
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // sender side
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.payload <= '0;
            send_gap      <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) expected_steps.push_back(gravity_step(in_if.payload));
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                in_if.payload <= pending_pairs.pop_front();
                in_if.valid   <= 1'b1;
                send_gap      <= steady_send ? 0 : pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver side and checking
    int take_gap = 0;
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            take_gap     <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.payload;
                if (expected_steps.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    fail_cnt++;
                end else begin
                    want = expected_steps.pop_front();
                    if (got.new_pos_x !== want.new_pos_x)
                        $display("%0t: new_pos_x exp %h got %h", $time, want.new_pos_x,
                                 got.new_pos_x);
                    if (got.new_pos_y !== want.new_pos_y)
                        $display("%0t: new_pos_y exp %h got %h", $time, want.new_pos_y,
                                 got.new_pos_y);
                    if (got.new_vel_x !== want.new_vel_x)
                        $display("%0t: new_vel_x exp %h got %h", $time, want.new_vel_x,
                                 got.new_vel_x);
                    if (got.new_vel_y !== want.new_vel_y)
                        $display("%0t: new_vel_y exp %h got %h", $time, want.new_vel_y,
                                 got.new_vel_y);
                    if (got.center_x !== want.center_x)
                        $display("%0t: center_x exp %h got %h", $time, want.center_x,
                                 got.center_x);
                    if (got.center_y !== want.center_y)
                        $display("%0t: center_y exp %h got %h", $time, want.center_y,
                                 got.center_y);
                    if (got.contact !== want.contact)
                        $display("%0t: contact exp %b got %b", $time, want.contact,
                                 got.contact);
                    if (got !== want) fail_cnt++;
                end
            end
            if (take_gap > 0) begin
                take_gap     <= take_gap - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                take_gap     <= steady_take ? 0 : pick_gap();
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_GRAVITY:   grav_k = data;
            CFG_TIME_STEP: step_k = data;
            CFG_MARGIN:    margin_k = data[MARGIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || in_if.valid || expected_steps.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
    endtask

    function automatic t_in_beat make_pair(input int kind);
        t_in_beat b;
        longint cx, cy;
        b.pos_x = $urandom();
        b.pos_y = $urandom();
        b.vel_x = $urandom();
        b.vel_y = $urandom();
        b.body_radius = RAD_W'($urandom());
        b.other_center_x = $urandom();
        b.other_center_y = $urandom();
        b.other_mass = MASS_W'($urandom());
        if (kind != 0) begin
            // a nearby partner so the force matters; small velocities for kind 1
            if (kind == 1) begin
                b.vel_x = $signed($urandom_range(65536 * 8)) - 65536 * 4;
                b.vel_y = $signed($urandom_range(65536 * 8)) - 65536 * 4;
            end
            cx = longint'(b.pos_x) + (longint'(b.body_radius) << FRAC);
            cy = longint'(b.pos_y) + (longint'(b.body_radius) << FRAC);
            cx = clamp_word(cx + longint'($urandom_range(1 << 25)) - (1 << 24));
            cy = clamp_word(cy + longint'($urandom_range(1 << 25)) - (1 << 24));
            b.other_center_x = cx[31:0];
            b.other_center_y = cy[31:0];
        end
        return b;
    endfunction

    task automatic queue_random(input int n);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(9);
            pending_pairs.push_back(make_pair(p < 3 ? 0 : (p < 8 ? 1 : 2)));
        end
    endtask

    function automatic t_in_beat pair_at(input int px, input int py, input int vx,
                                         input int vy, input int rad, input int ox,
                                         input int oy, input int m);
        t_in_beat b;
        b.pos_x = px;
        b.pos_y = py;
        b.vel_x = vx;
        b.vel_y = vy;
        b.body_radius = RAD_W'(rad);
        b.other_center_x = ox;
        b.other_center_y = oy;
        b.other_mass = MASS_W'(m);
        return b;
    endfunction

    initial begin
        localparam int MAXW = 32'h7fffffff;
        localparam int MINW = 32'h80000000;
        grav_k   = GRAVITY_RST;
        step_k   = TIME_STEP_RST;
        margin_k = MARGIN_RST;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats with reset constants
        steady_send = 1'b1;
        steady_take = 1'b1;
        // centre saturation high, then extreme positions and velocities
        pending_pairs.push_back(pair_at(MAXW, MAXW, 0, 0, 255, 0, 0, 65535));
        pending_pairs.push_back(pair_at(MINW, MINW, MINW, MAXW, 0, MAXW, MAXW, 65535));
        pending_pairs.push_back(pair_at(MAXW - 100, 5, MAXW, MINW, 0, MINW, 0, 1));
        // no contact: partner clear of the contact limit, then one lsb farther
        pending_pairs.push_back(pair_at(0, 0, 7, 7, 5, (20 << 16) + (5 << 16), 5 << 16, 9));
        pending_pairs.push_back(pair_at(0, 0, 7, 7, 5, (20 << 16) + (5 << 16) + 1, 5 << 16,
                                        9));
        pending_pairs.push_back(pair_at(100, -100, MAXW, MINW, 255, 100, -100, 65535));
        // partner one lsb beyond the contact limit: force saturates
        pending_pairs.push_back(pair_at(0, 0, MAXW - 5, MINW + 5, 0, (10 << 16) + 1, 0,
                                        65535));
        pending_pairs.push_back(pair_at(0, 0, 0, 0, 0, 0, -(11 << 16), 65535));
        // zero mass far away
        pending_pairs.push_back(pair_at(12345, -999, 3, -3, 1, MAXW, MINW, 0));
        pending_pairs.push_back(pair_at(-1, -1, -1, -1, 255, -1, -1, 1));
        pending_pairs.push_back(pair_at(1 << 20, 0, 0, 0, 0, -(1 << 24), (1 << 23), 40000));
        pending_pairs.push_back(pair_at(MAXW, MINW, MAXW, MINW, 128, MINW, MAXW, 65535));
        drain();

        // register extremes; margin carries junk in its upper bits
        write_reg(CFG_GRAVITY, 16'd0);
        write_reg(CFG_TIME_STEP, 16'd0);
        write_reg(CFG_MARGIN, 16'hff00);
        pending_pairs.push_back(pair_at(0, 0, 0, 0, 0, 0, 0, 65535));
        pending_pairs.push_back(pair_at(0, 0, 5, 5, 0, 1, 0, 65535));
        queue_random(8);
        drain();

        write_reg(CFG_GRAVITY, 16'hffff);
        write_reg(CFG_TIME_STEP, 16'hffff);
        write_reg(CFG_MARGIN, 16'h00ff);
        // unknown index must be ignored
        write_reg(t_cfg_idx'(2'd3), 16'h0000);
        pending_pairs.push_back(pair_at(0, 0, 0, 0, 255, (510 << 16) + (255 << 16), 255 << 16,
                                        5));
        pending_pairs.push_back(pair_at(0, 0, MAXW, MAXW, 0, (300 << 16), (300 << 16),
                                        65535));
        queue_random(300);
        drain();

        // random phases: busy stretches and bursty stretches
        for (int ph = 0; ph < 5; ph++) begin
            steady_send = (ph == 1);
            steady_take = (ph == 1 || ph == 3);
            if (ph == 4) begin
                write_reg(CFG_GRAVITY, GRAVITY_RST);
                write_reg(CFG_TIME_STEP, TIME_STEP_RST);
                write_reg(CFG_MARGIN, 16'(MARGIN_RST));
            end else begin
                write_reg(CFG_GRAVITY, 16'($urandom()));
                write_reg(CFG_TIME_STEP, 16'($urandom()));
                write_reg(CFG_MARGIN, 16'($urandom()));
            end
            queue_random(280);
            drain();
        end

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
